// ===== hw/rtl/lgs_pkg.sv =====
// Shared constants, types and helper functions for the Life generation stencil.
// Used by every module of the block but lgs_ram; depends on nothing.
`default_nettype none

package lgs_pkg;

  // Grid limits and the widths that follow from them.
  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = $clog2(MAX_ROWS);

  // Configuration register width is fixed by the register map.
  localparam int SIZE_W = 11;
  localparam int CFG_INDEX_W = 1;
  localparam int MIN_SIZE = 3;
  localparam int RESET_COLS = 750;
  localparam int RESET_ROWS = 750;

  // Row position modulo unit: dividend is row + rows - 1.
  localparam int DIV_W = SIZE_W + 1;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  // Result buffer.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Register map.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GRID_COLS = 1'b0,
    REG_GRID_ROWS = 1'b1
  } cfg_reg_t;

  // Status of the modulo unit as seen by the top level.
  typedef struct packed {
    logic busy;
    logic done;
  } mod_status_t;

  // Clamp a written size into [MIN_SIZE, hi].
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                    input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] res;
    res = v;
    if (v < SIZE_W'(MIN_SIZE)) begin
      res = SIZE_W'(MIN_SIZE);
    end else if (v > hi) begin
      res = hi;
    end
    return res;
  endfunction

  // Number of live cells in one column triple.
  function automatic logic [1:0] ones3(input logic [2:0] v);
    return {1'b0, v[0]} + {1'b0, v[1]} + {1'b0, v[2]};
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lgs_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port.
// Generic storage used for the two line stores; no package dependency.
`default_nettype none

module lgs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lgs_cell.sv =====
// One column cell of the 3x3 window: holds a column triple and hands it on.
// Depends on lgs_pkg for the column count function.
`default_nettype none

module lgs_cell (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       en,
  input  wire logic [2:0] col_in,
  output logic      [2:0] col_bits,
  output logic      [1:0] col_count
);

  // Shift the incoming column in whenever the window advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_bits <= '0;
    end else if (en) begin
      col_bits <= col_in;
    end
  end

  // Live count of the held column, used by the neighbor sum.
  assign col_count = lgs_pkg::ones3(col_bits);

endmodule

`default_nettype wire

// ===== hw/rtl/lgs_mod.sv =====
// Restoring remainder unit: one dividend bit per cycle.
// Recomputes the delayed row position after a size change; uses lgs_pkg.
`default_nettype none

module lgs_mod (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [lgs_pkg::DIV_W-1:0]  dividend,
  input  wire logic [lgs_pkg::SIZE_W-1:0] divisor,
  output lgs_pkg::mod_status_t            status,
  output logic      [lgs_pkg::ROW_W-1:0]  remainder
);

  logic [lgs_pkg::DIV_CNT_W-1:0] step_cnt;
  logic                          busy;
  logic                          done;
  logic [lgs_pkg::DIV_W-1:0]     dvd;
  logic [lgs_pkg::SIZE_W-1:0]    dsr;
  logic [lgs_pkg::SIZE_W-1:0]    trial;
  logic [lgs_pkg::SIZE_W-1:0]    diff;
  logic [lgs_pkg::ROW_W-1:0]     remainder_next;

  // One restoring step: bring down the next bit and subtract if it fits.
  always_comb begin
    trial = {remainder, dvd[lgs_pkg::DIV_W-1]};
    diff = trial - dsr;
    if (trial >= dsr) begin
      remainder_next = diff[lgs_pkg::ROW_W-1:0];
    end else begin
      remainder_next = trial[lgs_pkg::ROW_W-1:0];
    end
  end

  // Step counter and handshake flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step_cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step_cnt <= lgs_pkg::DIV_CNT_W'(lgs_pkg::DIV_W);
    end else if (busy) begin
      step_cnt <= step_cnt - 1'b1;
      if (step_cnt == lgs_pkg::DIV_CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Operand and partial remainder registers.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      remainder <= '0;
    end else if (busy) begin
      dvd <= {dvd[lgs_pkg::DIV_W-2:0], 1'b0};
      remainder <= remainder_next;
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

`default_nettype wire

// ===== hw/rtl/life_generation_stencil.sv =====
// Life generation stencil (birth on 3, survival on 2 or 3); border cells always come out dead.
// Throughput: one word per clock while cell_ready is high; the result for a cell leaves with
// the word grid_cols+1 later, through the stage 1 registers and the result buffer.
// A configuration write holds ready low while the 12-step remainder unit re-derives the
// delayed row position. Reset clears counters, window and buffer at once; the line stores
// are not cleared, and the first grid_cols+1 words give no result.
`default_nettype none

module life_generation_stencil (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cell_valid,
  output logic                                 cell_ready,
  input  wire logic                            cell_alive,
  output logic                                 result_valid,
  input  wire logic                            result_ready,
  output logic                                 next_alive,
  output logic                                 frame_last,
  input  wire logic                            cfg_write,
  input  wire logic [lgs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [lgs_pkg::SIZE_W-1:0]      cfg_data
);

  localparam int COL_W = lgs_pkg::COL_W;
  localparam int ROW_W = lgs_pkg::ROW_W;
  localparam int SIZE_W = lgs_pkg::SIZE_W;

  // Configuration and control state.
  logic [SIZE_W-1:0] grid_cols;
  logic [SIZE_W-1:0] grid_rows;
  logic              cfg_pending;
  logic [COL_W-1:0]  in_column;
  logic [ROW_W-1:0]  in_row;
  logic [ROW_W-1:0]  row_behind;
  logic              primed;

  // Stage 1 registers (line store data arrives here).
  logic              s1_valid;
  logic              s1_cell;
  logic [COL_W-1:0]  s1_col;
  logic              s1_emit;
  logic              s1_border;
  logic              s1_last;

  // Result buffer.
  logic [1:0]                   fifo_data [lgs_pkg::FIFO_DEPTH];
  logic [lgs_pkg::FIFO_PTR_W-1:0] wr_ptr;
  logic [lgs_pkg::FIFO_PTR_W-1:0] rd_ptr;
  logic [lgs_pkg::FIFO_CNT_W-1:0] fifo_count;
  logic [lgs_pkg::FIFO_CNT_W-1:0] fifo_count_next;

  // Stage 0 combinational signals.
  logic              accept;
  logic              push;
  logic              pop;
  logic [SIZE_W-1:0] cols_m1;
  logic [SIZE_W-1:0] rows_m1;
  logic [ROW_W-1:0]  row_behind2;
  logic [ROW_W-1:0]  orow;
  logic [COL_W-1:0]  ocol;
  logic              border;
  logic              last_cell;
  logic              primed_next;
  logic              col_wrap;
  logic              row_wrap;

  // Stage 1 combinational signals.
  logic              up_rd;
  logic              mid_rd;
  logic [2:0]        triple;
  logic [2:0]        a_bits;
  logic [1:0]        a_count;
  logic [2:0]        b_bits;
  logic [1:0]        b_count;
  logic [3:0]        nbrs;
  logic              alive;

  // Remainder unit interface.
  lgs_pkg::mod_status_t         mod_status;
  logic [lgs_pkg::DIV_W-1:0]    mod_dividend;
  logic [ROW_W-1:0]             mod_remainder;

  // Configuration registers hold the clamped sizes.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols <= SIZE_W'(lgs_pkg::RESET_COLS);
      grid_rows <= SIZE_W'(lgs_pkg::RESET_ROWS);
      cfg_pending <= 1'b0;
    end else begin
      cfg_pending <= cfg_write;
      if (cfg_write) begin
        case (lgs_pkg::cfg_reg_t'(cfg_index))
          lgs_pkg::REG_GRID_COLS: begin
            grid_cols <= lgs_pkg::clamp_size(cfg_data, SIZE_W'(lgs_pkg::MAX_COLS));
          end
          lgs_pkg::REG_GRID_ROWS: begin
            grid_rows <= lgs_pkg::clamp_size(cfg_data, SIZE_W'(lgs_pkg::MAX_ROWS));
          end
          default: begin
          end
        endcase
      end
    end
  end

  // After any write, recompute (row + rows - 1) mod rows for the delayed row.
  assign mod_dividend = lgs_pkg::DIV_W'(in_row) + lgs_pkg::DIV_W'(grid_rows)
                        - lgs_pkg::DIV_W'(1);

  lgs_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (cfg_pending),
    .dividend  (mod_dividend),
    .divisor   (grid_rows),
    .status    (mod_status),
    .remainder (mod_remainder)
  );

  // Input handshake: hold off during recompute and when the buffer could fill.
  assign cell_ready = !cfg_pending && !mod_status.busy && !mod_status.done &&
                      ((fifo_count + lgs_pkg::FIFO_CNT_W'(s1_valid))
                       < lgs_pkg::FIFO_CNT_W'(lgs_pkg::FIFO_DEPTH));
  assign accept = cell_valid && cell_ready;

  // Position of the delayed cell, one row and one column behind the input.
  always_comb begin
    cols_m1 = grid_cols - 1'b1;
    rows_m1 = grid_rows - 1'b1;
    if (row_behind == '0) begin
      row_behind2 = rows_m1[ROW_W-1:0];
    end else begin
      row_behind2 = row_behind - 1'b1;
    end
    if (in_column == '0) begin
      orow = row_behind2;
      ocol = cols_m1[COL_W-1:0];
    end else begin
      orow = row_behind;
      ocol = in_column - 1'b1;
    end
    border = (orow == '0) || (SIZE_W'(orow) >= rows_m1) ||
             (ocol == '0) || (SIZE_W'(ocol) >= cols_m1);
    last_cell = (SIZE_W'(orow) == rows_m1) && (SIZE_W'(ocol) == cols_m1);
    primed_next = primed || ((in_row != '0) && (in_column != '0)) ||
                  (in_row >= ROW_W'(2));
    col_wrap = (SIZE_W'(in_column) + 1'b1) >= grid_cols;
    row_wrap = (SIZE_W'(in_row) + 1'b1) >= grid_rows;
  end

  // Raster counters, warm-up flag and the tracked delayed row.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_column <= '0;
      in_row <= '0;
      row_behind <= ROW_W'(lgs_pkg::RESET_ROWS - 1);
      primed <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (mod_status.done) begin
        row_behind <= mod_remainder;
      end
      if (accept) begin
        primed <= primed_next;
        if (col_wrap) begin
          in_column <= '0;
          if (row_wrap) begin
            in_row <= '0;
            row_behind <= rows_m1[ROW_W-1:0];
          end else begin
            in_row <= in_row + 1'b1;
            row_behind <= in_row;
          end
        end else begin
          in_column <= in_column + 1'b1;
        end
      end
    end
  end

  // Stage 1 payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cell <= cell_alive;
      s1_col <= in_column;
      s1_emit <= primed_next;
      s1_border <= border;
      s1_last <= last_cell;
    end
  end

  // Line stores: read at the input column, write back in the cycle after.
  lgs_ram #(
    .WIDTH (1),
    .DEPTH (lgs_pkg::MAX_COLS),
    .ADDR_W(COL_W)
  ) u_row_upper (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (mid_rd),
    .re    (accept),
    .raddr (in_column),
    .rdata (up_rd)
  );

  lgs_ram #(
    .WIDTH (1),
    .DEPTH (lgs_pkg::MAX_COLS),
    .ADDR_W(COL_W)
  ) u_row_middle (
    .clk   (clk),
    .we    (s1_valid),
    .waddr (s1_col),
    .wdata (s1_cell),
    .re    (accept),
    .raddr (in_column),
    .rdata (mid_rd)
  );

  // Window chain: the new column plus the two held columns form the 3x3 window.
  assign triple = {s1_cell, mid_rd, up_rd};

  lgs_cell u_cell_a (
    .clk       (clk),
    .rst       (rst),
    .en        (s1_valid),
    .col_in    (triple),
    .col_bits  (a_bits),
    .col_count (a_count)
  );

  lgs_cell u_cell_b (
    .clk       (clk),
    .rst       (rst),
    .en        (s1_valid),
    .col_in    (a_bits),
    .col_bits  (b_bits),
    .col_count (b_count)
  );

  // Neighbor sum excludes the center, which is the middle bit of cell a.
  always_comb begin
    nbrs = 4'(lgs_pkg::ones3(triple)) + 4'(a_count) + 4'(b_count) - 4'(a_bits[1]);
    alive = !s1_border && ((nbrs == 4'd3) || (a_bits[1] && (nbrs == 4'd2)));
  end

  // Result buffer.
  assign push = s1_valid && s1_emit;
  assign pop = result_valid && result_ready;
  assign fifo_count_next = fifo_count + lgs_pkg::FIFO_CNT_W'(push)
                           - lgs_pkg::FIFO_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fifo_count <= '0;
    end else begin
      fifo_count <= fifo_count_next;
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_data[wr_ptr] <= {s1_last, alive};
    end
  end

  assign result_valid = (fifo_count != '0);
  assign next_alive = fifo_data[rd_ptr][0];
  assign frame_last = fifo_data[rd_ptr][1];

  // A stage 1 word must come from an accept in the previous cycle.
  assert property (@(posedge clk) disable iff (rst) s1_valid |-> $past(accept))
    else $error("stage 1 word without a preceding accept");

  // The buffer never overflows: a push into a full buffer needs a pop.
  assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> (fifo_count < lgs_pkg::FIFO_CNT_W'(lgs_pkg::FIFO_DEPTH)))
    else $error("result buffer overflow");

  // Outside a recompute, the tracked delayed row stays inside the grid.
  assert property (@(posedge clk) disable iff (rst)
    (!cfg_pending && !mod_status.busy && !mod_status.done) |->
      (SIZE_W'(row_behind) < grid_rows))
    else $error("delayed row outside the grid");

endmodule

`default_nettype wire
